// ===== sv/stt_pkg.sv =====
`timescale 1ns / 1ps
package stt_pkg;

    localparam int LOC_W   = 10;
    localparam int TIME_W  = 8;
    localparam int AGENT_W = 10;
    localparam int OCC_AW  = LOC_W + TIME_W;
    localparam int OCC_DW  = AGENT_W + 1;
    localparam int GOAL_W  = TIME_W + 1;
    localparam int HOLD_W  = TIME_W + 1;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 48;

    localparam logic [GOAL_W-1:0] NO_GOAL = {1'b1, {TIME_W{1'b0}}};

    // operation codes carried in tuser
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_HOLD   = 2'd3;

    // result word, conflict in the lowest bit
    typedef struct packed {
        logic [TIME_W-1:0]  makespan_now;
        logic [HOLD_W-1:0]  holding_time;
        logic               target_hit;
        logic [AGENT_W-1:0] edge_agent;
        logic               edge_hit;
        logic [AGENT_W-1:0] vertex_agent;
        logic               vertex_hit;
        logic               conflict;
    } result_t;

endpackage

// ===== sv/stt_ram.sv =====
`timescale 1ns / 1ps
module stt_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/space_time_reservation_table.sv =====
`timescale 1ns / 1ps
// an accepted word runs to a registered result: insert and delete write their cells,
// delete of the makespan goal rescans the goal memory, one entry a cycle,
// conflict query makes up to three reads of the one occupancy read port,
// holding time scans down the time axis, one cell a cycle
// one word in flight at a time; the next word is taken once the result is registered
// after reset a clearing pass over all 262144 cells empties the table before s_tready rises
module space_time_reservation_table
    import stt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,  // agent, location, from_location, time_req
    input  logic [1:0]      s_tuser,  // op
    input  logic            s_tlast,  // last
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [OUT_W-1:0] m_tdata  // conflict, vertex_hit, vertex_agent, edge_hit,
                                      // edge_agent, target_hit, holding_time, makespan_now
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_Q1, ST_Q2, ST_Q3, ST_HS, ST_MS, ST_PUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [OCC_AW-1:0]   cnt_reg, cnt_next;
    logic [1:0]          op_reg, op_next;
    logic [AGENT_W-1:0]  agent_reg, agent_next;
    logic [LOC_W-1:0]    loc_reg, loc_next;
    logic [LOC_W-1:0]    from_reg, from_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic                last_reg, last_next;
    logic [OCC_DW-1:0]   prev_reg, prev_next;
    logic [TIME_W-1:0]   scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [TIME_W-1:0]   max_reg, max_next;
    logic [TIME_W-1:0]   makespan_reg, makespan_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                mvalid_reg, mvalid_next;

    logic                occ_we;
    logic [OCC_AW-1:0]   occ_waddr, occ_raddr;
    logic [OCC_DW-1:0]   occ_wdata, occ_rd;
    logic                goal_we;
    logic [LOC_W-1:0]    goal_waddr, goal_raddr;
    logic [GOAL_W-1:0]   goal_wdata, goal_rd;
    logic [TIME_W-1:0]   mx;

    stt_ram #(.AW(OCC_AW), .DW(OCC_DW)) u_occ (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rd)
    );

    stt_ram #(.AW(LOC_W), .DW(GOAL_W)) u_goal (
        .clk   (clk),
        .we    (goal_we),
        .waddr (goal_waddr),
        .wdata (goal_wdata),
        .raddr (goal_raddr),
        .rdata (goal_rd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_reg};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        agent_next    = agent_reg;
        loc_next      = loc_reg;
        from_next     = from_reg;
        time_next     = time_reg;
        last_next     = last_reg;
        prev_next     = prev_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        max_next      = max_reg;
        makespan_next = makespan_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        occ_we        = 1'b0;
        occ_waddr     = {loc_reg, time_reg};
        occ_wdata     = '0;
        occ_raddr     = {loc_reg, time_reg};
        goal_we       = 1'b0;
        goal_waddr    = loc_reg;
        goal_wdata    = NO_GOAL;
        goal_raddr    = loc_reg;
        mx            = max_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                occ_we     = 1'b1;
                occ_waddr  = cnt_reg;
                goal_we    = (cnt_reg[OCC_AW-1:LOC_W] == '0);
                goal_waddr = cnt_reg[LOC_W-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    agent_next = s_tdata[9:0];
                    loc_next   = s_tdata[19:10];
                    from_next  = s_tdata[29:20];
                    time_next  = s_tdata[37:30];
                    last_next  = s_tlast;
                    res_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        occ_we    = 1'b1;
                        occ_wdata = {1'b1, agent_reg};
                        if (last_reg)
                        begin
                            goal_we    = 1'b1;
                            goal_wdata = {1'b0, time_reg};
                            if (time_reg > makespan_reg)
                            begin
                                makespan_next = time_reg;
                            end
                        end
                        state_next = ST_PUSH;
                    end
                    OP_DELETE:
                    begin
                        occ_we     = 1'b1;
                        state_next = ST_PUSH;
                        if (last_reg)
                        begin
                            goal_we = 1'b1;
                            if (makespan_reg == time_reg)
                            begin
                                cnt_next   = '0;
                                pend_next  = 1'b0;
                                max_next   = '0;
                                state_next = ST_MS;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        state_next = ST_Q1;
                    end
                    default:
                    begin
                        occ_raddr  = {loc_reg, {TIME_W{1'b1}}};
                        scan_next  = '1;
                        state_next = ST_HS;
                    end
                endcase
            end
            // vertex cell and goal arrive
            ST_Q1:
            begin
                res_next.vertex_hit   = occ_rd[OCC_DW-1];
                res_next.vertex_agent = occ_rd[AGENT_W-1:0];
                res_next.target_hit   = (goal_rd <= {1'b0, time_reg});
                if (time_reg != '0)
                begin
                    occ_raddr  = {loc_reg, time_reg - 1'b1};
                    state_next = ST_Q2;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_Q2:
            begin
                prev_next  = occ_rd;
                occ_raddr  = {from_reg, time_reg};
                state_next = ST_Q3;
            end
            // swap test against the from cell
            ST_Q3:
            begin
                if (prev_reg[OCC_DW-1] && (occ_rd == prev_reg))
                begin
                    res_next.edge_hit   = 1'b1;
                    res_next.edge_agent = occ_rd[AGENT_W-1:0];
                end
                state_next = ST_PUSH;
            end
            // walk down from the top timestep to the first held cell or the requested time
            ST_HS:
            begin
                if (occ_rd[OCC_DW-1])
                begin
                    res_next.holding_time = {1'b0, scan_reg} + 1'b1;
                    state_next            = ST_PUSH;
                end
                else if (scan_reg == time_reg)
                begin
                    res_next.holding_time = {1'b0, time_reg};
                    state_next            = ST_PUSH;
                end
                else
                begin
                    scan_next = scan_reg - 1'b1;
                    occ_raddr = {loc_reg, scan_reg - 1'b1};
                end
            end
            // makespan rescan over all goals
            ST_MS:
            begin
                if (pend_reg && !goal_rd[GOAL_W-1] && (goal_rd[TIME_W-1:0] > max_reg))
                begin
                    mx = goal_rd[TIME_W-1:0];
                end
                max_next = mx;
                if (!cnt_reg[LOC_W])
                begin
                    goal_raddr = cnt_reg[LOC_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                else
                begin
                    makespan_next = mx;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    out_next              = res_reg;
                    out_next.conflict     = res_reg.vertex_hit | res_reg.edge_hit
                                            | res_reg.target_hit;
                    out_next.makespan_now = makespan_reg;
                    mvalid_next           = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            makespan_reg <= '0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            makespan_reg <= makespan_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        agent_reg <= agent_next;
        loc_reg   <= loc_next;
        from_reg  <= from_next;
        time_reg  <= time_next;
        last_reg  <= last_next;
        prev_reg  <= prev_next;
        scan_reg  <= scan_next;
        max_reg   <= max_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

`ifndef SYNTH
    // no word is taken while the table is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("word accepted during clearing pass");

    // makespan only moves on an insert/delete step or at the end of a rescan
    a_makespan_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(makespan_reg) |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_MS))
        else $error("makespan changed outside an update");

    // holding time never falls below the requested time
    a_hold_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && op_reg == OP_HOLD)
        |-> (res_reg.holding_time >= {1'b0, time_reg}))
        else $error("holding time below requested time");
`endif

endmodule

// ===== sim/stt_checker.sv =====
`timescale 1ns / 1ps
module stt_checker
    import stt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             s_tlast,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               errors,
    output int               pending
);

    // shadow copy of the reservation table
    logic [OCC_DW-1:0] cells [0:(1<<OCC_AW)-1];
    logic [GOAL_W-1:0] goals [0:(1<<LOC_W)-1];
    logic [TIME_W-1:0] span;
    result_t           expected_results [$];

    initial
    begin
        for (int i = 0; i < (1 << OCC_AW); i++)
            cells[i] = '0;
        for (int i = 0; i < (1 << LOC_W); i++)
            goals[i] = NO_GOAL;
        span = '0;
        errors = 0;
        pending = 0;
    end

    function automatic logic [OCC_AW-1:0] cell_addr(logic [LOC_W-1:0] l, logic [TIME_W-1:0] t);
        return {l, t};
    endfunction

    // apply one word to the shadow table and return the result it yields
    function automatic result_t apply_word(logic [1:0] op, logic [AGENT_W-1:0] ag,
                                           logic [LOC_W-1:0] l, logic [LOC_W-1:0] fl,
                                           logic [TIME_W-1:0] t, logic lst);
        result_t r;
        logic [OCC_DW-1:0] c;
        logic [OCC_DW-1:0] prev;
        logic [OCC_DW-1:0] fc;
        logic [GOAL_W-1:0] m;
        int s;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                cells[cell_addr(l, t)] = {1'b1, ag};
                if (lst)
                begin
                    goals[l] = {1'b0, t};
                    if (t > span)
                        span = t;
                end
            end
            OP_DELETE:
            begin
                cells[cell_addr(l, t)] = '0;
                if (lst)
                begin
                    goals[l] = NO_GOAL;
                    if (span == t)
                    begin
                        m = '0;
                        for (int i = 0; i < (1 << LOC_W); i++)
                            if (goals[i] < NO_GOAL && goals[i] > m)
                                m = goals[i];
                        span = m[TIME_W-1:0];
                    end
                end
            end
            OP_QUERY:
            begin
                c = cells[cell_addr(l, t)];
                if (c[AGENT_W])
                begin
                    r.vertex_hit = 1'b1;
                    r.vertex_agent = c[AGENT_W-1:0];
                end
                if (t >= 1)
                begin
                    prev = cells[cell_addr(l, t - 1'b1)];
                    fc = cells[cell_addr(fl, t)];
                    if (prev[AGENT_W] && fc == prev)
                    begin
                        r.edge_hit = 1'b1;
                        r.edge_agent = fc[AGENT_W-1:0];
                    end
                end
                r.target_hit = (goals[l] <= {1'b0, t});
                r.conflict = r.vertex_hit | r.edge_hit | r.target_hit;
            end
            default:
            begin
                // scan down from the top of the time axis
                s = 1 << TIME_W;
                while (s > t && !cells[{l, 8'(s - 1)}][AGENT_W])
                    s--;
                r.holding_time = (s > t) ? HOLD_W'(s) : HOLD_W'(t);
            end
        endcase
        r.makespan_now = span;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // predict on accepted input words, compare on accepted result words
    always @(posedge clk)
    begin
        result_t e;
        result_t a;
        if (rst_n && s_tvalid && s_tready)
            expected_results.insert(expected_results.size(),
                                    apply_word(s_tuser, s_tdata[9:0], s_tdata[19:10],
                                               s_tdata[29:20], s_tdata[37:30], s_tlast));
        if (rst_n && m_tvalid && m_tready)
        begin
            a = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("conflict", e.conflict, a.conflict);
                check_field("vertex_hit", e.vertex_hit, a.vertex_hit);
                check_field("vertex_agent", e.vertex_agent, a.vertex_agent);
                check_field("edge_hit", e.edge_hit, a.edge_hit);
                check_field("edge_agent", e.edge_agent, a.edge_agent);
                check_field("target_hit", e.target_hit, a.target_hit);
                check_field("holding_time", e.holding_time, a.holding_time);
                check_field("makespan_now", e.makespan_now, a.makespan_now);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench
    import stt_pkg::*;
();

    localparam int WORD_COUNT = 1850;
    localparam int IDLE_LIMIT = 1000000;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [1:0]       s_tuser;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               errors;
    int               pending;
    int               words_sent;
    int               burst_left;
    int               idle_cycles;

    typedef struct {
        logic [AGENT_W-1:0] ag;
        logic [LOC_W-1:0]   locs [8];
        logic [TIME_W-1:0]  t0;
        int                 len;
    } path_t;

    path_t stored_paths [$];

    space_time_reservation_table dut (.*);

    stt_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall pattern: alternating phases of always-ready and random stalls
    initial
    begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (phase == 0)
                phase = $urandom_range(1, 60);
            phase--;
            if (phase % 40 < 20)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on cycles with no accepted word on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // drive one word and wait for it to be taken; gaps fall between bursts
    task automatic send_word(logic [1:0] op, logic [AGENT_W-1:0] ag, logic [LOC_W-1:0] l,
                             logic [LOC_W-1:0] fl, logic [TIME_W-1:0] t, logic lst);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= lst;
        s_tdata  <= {2'b00, t, fl, l, ag};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    function automatic logic [LOC_W-1:0] pick_loc();
        if ($urandom_range(0, 9) == 0)
            return LOC_W'($urandom);
        return LOC_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        if ($urandom_range(0, 4) == 0)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(0, 20));
    endfunction

    task automatic insert_path();
        path_t p;
        p.ag = AGENT_W'($urandom);
        p.len = $urandom_range(1, 6);
        p.t0 = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom_range(200, 250))
                                           : TIME_W'($urandom_range(0, 20));
        p.locs[0] = pick_loc();
        for (int i = 1; i < p.len; i++)
            p.locs[i] = ($urandom_range(0, 2) == 0) ? p.locs[i-1]
                                                    : LOC_W'(p.locs[i-1] + $urandom_range(0, 2) - 1);
        for (int i = 0; i < p.len; i++)
            send_word(OP_INSERT, p.ag, p.locs[i], '0, TIME_W'(p.t0 + i), i == p.len - 1);
        stored_paths.insert(stored_paths.size(), p);
    endtask

    task automatic delete_path();
        path_t p;
        int k;
        k = $urandom_range(0, stored_paths.size() - 1);
        p = stored_paths[k];
        stored_paths.delete(k);
        for (int i = 0; i < p.len; i++)
            send_word(OP_DELETE, p.ag, p.locs[i], '0, TIME_W'(p.t0 + i), i == p.len - 1);
    endtask

    initial
    begin
        int pick;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        s_tlast = 1'b0;
        words_sent = 0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_word(OP_HOLD, 10'd1023, 10'd1023, 10'd1023, 8'd0, 1'b1);
        send_word(OP_QUERY, 10'd0, 10'd1023, 10'd0, 8'd255, 1'b0);
        send_word(OP_INSERT, 10'd1023, 10'd1023, 10'd0, 8'd254, 1'b0);
        send_word(OP_INSERT, 10'd1023, 10'd1023, 10'd0, 8'd255, 1'b1);
        send_word(OP_INSERT, 10'd5, 10'd0, 10'd0, 8'd0, 1'b0);
        send_word(OP_INSERT, 10'd5, 10'd1, 10'd0, 8'd1, 1'b1);
        send_word(OP_INSERT, 10'd7, 10'd0, 10'd0, 8'd1, 1'b1);
        send_word(OP_QUERY, 10'd0, 10'd1023, 10'd1023, 8'd255, 1'b0);
        send_word(OP_QUERY, 10'd0, 10'd0, 10'd1, 8'd0, 1'b0);
        send_word(OP_QUERY, 10'd0, 10'd0, 10'd1, 8'd1, 1'b0);
        send_word(OP_QUERY, 10'd0, 10'd1, 10'd0, 8'd1, 1'b0);
        send_word(OP_QUERY, 10'd0, 10'd1023, 10'd1023, 8'd254, 1'b0);
        send_word(OP_HOLD, 10'd0, 10'd1023, 10'd0, 8'd0, 1'b0);
        send_word(OP_HOLD, 10'd0, 10'd1023, 10'd0, 8'd255, 1'b0);
        send_word(OP_HOLD, 10'd0, 10'd0, 10'd0, 8'd100, 1'b0);
        // overwrite a held cell, then delete it as another agent
        send_word(OP_INSERT, 10'd9, 10'd0, 10'd0, 8'd0, 1'b0);
        send_word(OP_DELETE, 10'd3, 10'd0, 10'd0, 8'd0, 1'b0);
        // removing the makespan goal forces a rescan
        send_word(OP_DELETE, 10'd1023, 10'd1023, 10'd0, 8'd255, 1'b1);
        send_word(OP_DELETE, 10'd1023, 10'd1023, 10'd0, 8'd254, 1'b0);
        send_word(OP_QUERY, 10'd0, 10'd0, 10'd0, 8'd1, 1'b0);
        send_word(OP_DELETE, 10'd0, 10'd0, 10'd0, 8'd1, 1'b1);
        send_word(OP_DELETE, 10'd0, 10'd1, 10'd0, 8'd1, 1'b1);

        // random traffic: mostly whole paths, queries near them, some noise
        while (words_sent < WORD_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35 || (pick < 55 && stored_paths.size() == 0))
                insert_path();
            else if (pick < 55)
                delete_path();
            else if (pick < 82)
                send_word(OP_QUERY, AGENT_W'($urandom), pick_loc(), pick_loc(), pick_time(),
                          1'($urandom));
            else if (pick < 94)
                send_word(OP_HOLD, AGENT_W'($urandom), pick_loc(), LOC_W'($urandom),
                          pick_time(), 1'($urandom));
            else
                send_word(2'($urandom), AGENT_W'($urandom), LOC_W'($urandom), LOC_W'($urandom),
                          TIME_W'($urandom), 1'($urandom));
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
